@@ design/siis_pkg.sv @@
// ----------------------------------------------------------------------------
// siis_pkg
// Shared types and constants for the snapshot interface I/O shadow block.
// ----------------------------------------------------------------------------
package siis_pkg;

  // memory geometry
  localparam int unsigned RamBytes = 8192;
  localparam int unsigned RomBytes = 8192;
  localparam int unsigned MemAw    = $clog2(RamBytes);
  localparam logic [7:0]  MemFill  = 8'hFF;

  // stream payload widths
  localparam int unsigned CmdW     = 3;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 16;

  // request kinds carried in tuser
  typedef enum logic [CmdW-1:0] {
    CmdIoWrite  = 3'd0,
    CmdMemRead  = 3'd1,
    CmdMemWrite = 3'd2,
    CmdStop     = 3'd3,
    CmdReset    = 3'd4,
    CmdRomLoad  = 3'd5
  } cmd_e;

  // i/o port decode
  localparam logic [15:0] PagingPortMask = 16'hFFFC;
  localparam logic [15:0] PagingPort     = 16'hFEE8;
  localparam logic [7:0]  GaPortHi       = 8'h7F;
  localparam logic [7:0]  CrtcIndexHi    = 8'hBC;
  localparam logic [7:0]  CrtcDataHi     = 8'hBD;
  localparam logic [7:0]  PpiCtrlHi      = 8'hF7;

  // gate array function codes (data bits 7:6)
  localparam logic [1:0]  GaFnPen    = 2'd0;
  localparam logic [1:0]  GaFnColour = 2'd1;

  // shadow byte locations in the cartridge ram
  localparam logic [MemAw-1:0] ShadowPen       = 13'h1FCF;
  localparam logic [MemAw-1:0] ShadowBorder    = 13'h1FDF;
  localparam logic [MemAw-1:0] ShadowPalette   = 13'h1F90;
  localparam logic [MemAw-1:0] ShadowCrtcRegs  = 13'h1DB0;
  localparam logic [MemAw-1:0] ShadowCrtcIndex = 13'h1CFF;
  localparam logic [MemAw-1:0] ShadowPpi       = 13'h17FF;

  // cpu address decode
  localparam logic [2:0]  PageLow    = 3'd0;
  localparam logic [2:0]  PageSecond = 3'd1;
  localparam logic [14:0] HideWord   = 15'h0032;  // 0064/0065
  localparam logic [7:0]  CrtcRegCnt = 8'h10;

  // which memory feeds the read byte of a result
  typedef enum logic [1:0] {
    SelNone = 2'd0,
    SelRom  = 2'd1,
    SelRam  = 2'd2
  } rd_sel_e;

  typedef struct packed {
    logic claimed;
    logic nmi;
    logic paging;
    logic visible;
    logic stop;
  } res_flags_t;

endpackage

@@ design/snapshot_interface_io_shadow.sv @@
// ----------------------------------------------------------------------------
// snapshot_interface_io_shadow
// Snapshot cartridge model: paging control, i/o shadowing and cartridge memory.
// ----------------------------------------------------------------------------
// One bus event per request, one result per request. A request is taken every
// cycle while the output side keeps up; its result passes through s1, where the
// registered read port of the cartridge rom or ram delivers the byte,
// and then waits in the output register. Every request touches at most one byte
// of one memory, so a write in one cycle is seen by a read in the next without
// forwarding. After reset a clearing pass fills all 8192 bytes of both memories
// with FF, one address per cycle; s_axis_tready_o stays low until it is done.
module snapshot_interface_io_shadow (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [15:0] port, [31:16] address, [39:32] data, [40] rom_enable_low_page,
  // [41] rom_enable_second_page, [47:42] zero
  input  logic [siis_pkg::InDataW-1:0]     s_axis_tdata_i,
  // [2:0] cmd
  input  logic [siis_pkg::CmdW-1:0]        s_axis_tuser_i,
  // result stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [0] claimed, [8:1] read_data, [9] nmi_pulse, [10] paging_on,
  // [11] is_visible, [12] stop_latched, [15:13] zero
  output logic [siis_pkg::OutDataW-1:0]    m_axis_tdata_o
);
  import siis_pkg::*;

  // request fields
  cmd_e        cmd;
  logic [15:0] io_port;
  logic [15:0] cpu_addr;
  logic [7:0]  wr_byte;
  logic        en_low;
  logic        en_second;

  assign cmd       = cmd_e'(s_axis_tuser_i);
  assign io_port   = s_axis_tdata_i[15:0];
  assign cpu_addr  = s_axis_tdata_i[31:16];
  assign wr_byte   = s_axis_tdata_i[39:32];
  assign en_low    = s_axis_tdata_i[40];
  assign en_second = s_axis_tdata_i[41];

  // cartridge state registers
  logic active_q, active_d;
  logic visible_q, visible_d;
  logic stop_q, stop_d;
  logic [7:0] pen_q, pen_d;
  logic [7:0] crtc_q, crtc_d;

  // clearing pass after reset
  logic             clr_busy_q;
  logic [MemAw-1:0] clr_addr_q;

  // pipeline: s1 waits for the memory read, out register holds the result
  logic        s1_valid_q;
  res_flags_t  s1_flags_q;
  rd_sel_e     s1_sel_q;
  logic        m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  logic s1_adv;
  logic in_ready;
  logic accept;

  assign s1_adv   = !m_valid_q || m_axis_tready_i;
  assign in_ready = !clr_busy_q && (!s1_valid_q || s1_adv);
  assign accept   = s_axis_tvalid_i && in_ready;

  // memory ports as decoded from the request
  logic             ram_we_req;
  logic [MemAw-1:0] ram_waddr_req;
  logic             rom_we_req;
  logic             ram_re;
  logic             rom_re;
  res_flags_t       flags_d;
  rd_sel_e          sel_d;

  always_comb begin
    active_d      = active_q;
    visible_d     = visible_q;
    stop_d        = stop_q;
    pen_d         = pen_q;
    crtc_d        = crtc_q;
    ram_we_req    = 1'b0;
    ram_waddr_req = '0;
    rom_we_req    = 1'b0;
    ram_re        = 1'b0;
    rom_re        = 1'b0;
    sel_d         = SelNone;
    flags_d       = '0;

    if (accept) begin
      unique case (cmd)
        CmdIoWrite: begin
          // paging control ports
          if ((io_port & PagingPortMask) == PagingPort) begin
            active_d = !io_port[1] && visible_q;
          end
          // shadow copies of video and ppi writes
          unique case (io_port[15:8])
            GaPortHi: begin
              ram_we_req = 1'b1;
              if (wr_byte[7:6] == GaFnPen) begin
                pen_d         = wr_byte;
                ram_waddr_req = ShadowPen;
              end else if (wr_byte[7:6] == GaFnColour) begin
                if (pen_q[4]) begin
                  ram_waddr_req = ShadowBorder;
                end else begin
                  ram_waddr_req = ShadowPalette | {{(MemAw-4){1'b0}}, pen_q[3:0]};
                end
              end else begin
                ram_waddr_req = ShadowPen | {{(MemAw-6){1'b0}}, wr_byte[7:6], 4'b0000};
              end
            end
            CrtcIndexHi: begin
              crtc_d        = wr_byte;
              ram_we_req    = 1'b1;
              ram_waddr_req = ShadowCrtcIndex;
            end
            CrtcDataHi: begin
              // only the sixteen crtc registers are shadowed
              if (crtc_q < CrtcRegCnt) begin
                ram_we_req    = 1'b1;
                ram_waddr_req = ShadowCrtcRegs | {{(MemAw-4){1'b0}}, crtc_q[3:0]};
              end
            end
            PpiCtrlHi: begin
              ram_we_req    = 1'b1;
              ram_waddr_req = ShadowPpi;
            end
            default: ;
          endcase
        end
        CmdMemRead, CmdMemWrite: begin
          if (active_q) begin
            if (cpu_addr[15:13] == PageLow && en_low) begin
              // rom page: reads served, writes swallowed
              flags_d.claimed = 1'b1;
              if (cmd == CmdMemRead) begin
                rom_re = 1'b1;
                sel_d  = SelRom;
              end
            end else if (cpu_addr[15:13] == PageSecond && en_second) begin
              flags_d.claimed = 1'b1;
              if (cmd == CmdMemRead) begin
                ram_re = 1'b1;
                sel_d  = SelRam;
              end else begin
                ram_we_req    = 1'b1;
                ram_waddr_req = cpu_addr[MemAw-1:0];
              end
            end
            // reading the hide location makes the cartridge invisible
            if (cmd == CmdMemRead && cpu_addr[15:1] == HideWord) begin
              visible_d = 1'b0;
            end
          end
        end
        CmdStop: begin
          if (!stop_q) begin
            stop_d      = 1'b1;
            active_d    = 1'b1;
            visible_d   = 1'b1;
            flags_d.nmi = 1'b1;
          end
        end
        CmdReset: begin
          active_d  = 1'b0;
          visible_d = 1'b1;
          stop_d    = 1'b0;
        end
        CmdRomLoad: begin
          if (cpu_addr[15:13] == PageLow) begin
            rom_we_req = 1'b1;
          end
        end
        default: ;
      endcase
    end

    flags_d.paging  = active_d;
    flags_d.visible = visible_d;
    flags_d.stop    = stop_d;
  end

  // memory write ports, taken over by the clearing pass after reset
  logic             ram_we;
  logic [MemAw-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic             rom_we;
  logic [MemAw-1:0] rom_waddr;
  logic [7:0]       rom_wdata;
  logic [7:0]       ram_rdata;
  logic [7:0]       rom_rdata;

  assign ram_we    = clr_busy_q || ram_we_req;
  assign ram_waddr = clr_busy_q ? clr_addr_q : ram_waddr_req;
  assign ram_wdata = clr_busy_q ? MemFill : wr_byte;
  assign rom_we    = clr_busy_q || rom_we_req;
  assign rom_waddr = clr_busy_q ? clr_addr_q : cpu_addr[MemAw-1:0];
  assign rom_wdata = clr_busy_q ? MemFill : wr_byte;

  siis_ram #(
    .WIDTH(8),
    .DEPTH(RamBytes)
  ) u_shadow_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(cpu_addr[MemAw-1:0]),
    .rdata_o(ram_rdata)
  );

  siis_ram #(
    .WIDTH(8),
    .DEPTH(RomBytes)
  ) u_system_rom (
    .clk_i  (clk_i),
    .we_i   (rom_we),
    .waddr_i(rom_waddr),
    .wdata_i(rom_wdata),
    .re_i   (rom_re),
    .raddr_i(cpu_addr[MemAw-1:0]),
    .rdata_o(rom_rdata)
  );

  // read byte of the request in s1, valid while s1 holds it
  logic [7:0] rd_byte;

  always_comb begin
    case (s1_sel_q)
      SelRom:  rd_byte = rom_rdata;
      SelRam:  rd_byte = ram_rdata;
      default: rd_byte = 8'h00;
    endcase
  end

  // state and clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      visible_q  <= 1'b1;
      stop_q     <= 1'b0;
      pen_q      <= '0;
      crtc_q     <= '0;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      active_q  <= active_d;
      visible_q <= visible_d;
      stop_q    <= stop_d;
      pen_q     <= pen_d;
      crtc_q    <= crtc_d;
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (&clr_addr_q) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= accept;
      end
      if (s1_valid_q && s1_adv) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_flags_q <= flags_d;
      s1_sel_q   <= sel_d;
    end
    if (s1_valid_q && s1_adv) begin
      m_data_q <= {3'b000, s1_flags_q.stop, s1_flags_q.visible, s1_flags_q.paging,
                   s1_flags_q.nmi, rd_byte, s1_flags_q.claimed};
    end
  end

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

@@ design/siis_ram.sv @@
// ----------------------------------------------------------------------------
// siis_ram
// Generic single-clock ram, one write port and one registered read port.
// ----------------------------------------------------------------------------
module siis_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/siis_checker.sv @@
// ----------------------------------------------------------------------------
// siis_checker
// Port-level checks for the snapshot interface block, bound to its top level.
// ----------------------------------------------------------------------------
module siis_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [siis_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import siis_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // an nmi leaves the cartridge paged in, visible and stopped
  a_nmi_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[9] |->
      m_axis_tdata_o[10] && m_axis_tdata_o[11] && m_axis_tdata_o[12])
    else $error("nmi without paging, visibility and stop");

  // a claimed access keeps paging on
  a_claim_paging: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |-> m_axis_tdata_o[10])
    else $error("claimed access with paging off");

  // unclaimed results carry no read byte
  a_unclaimed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[8:1] == 8'h00)
    else $error("read byte on unclaimed result");

endmodule

bind snapshot_interface_io_shadow siis_checker u_siis_checker (.*);
